FILE: design/edid_pkg.sv
package edid_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int POS_W       = 8;

   typedef logic [3:0] kind_type;

   localparam kind_type KIND_HEADER      = 4'd0;
   localparam kind_type KIND_MAKER       = 4'd1;
   localparam kind_type KIND_PRODUCT     = 4'd2;
   localparam kind_type KIND_SERIAL      = 4'd3;
   localparam kind_type KIND_DATE        = 4'd4;
   localparam kind_type KIND_VERSION     = 4'd5;
   localparam kind_type KIND_INPUT       = 4'd6;
   localparam kind_type KIND_SIZE        = 4'd7;
   localparam kind_type KIND_GAMMA       = 4'd8;
   localparam kind_type KIND_FEATURES    = 4'd9;
   localparam kind_type KIND_CHROMA      = 4'd10;
   localparam kind_type KIND_ESTABLISHED = 4'd11;
   localparam kind_type KIND_RESERVED    = 4'd12;
   localparam kind_type KIND_STANDARD    = 4'd13;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             header_good;
      logic [23:0]      recent;
      logic [15:0]      chroma;
      logic             digital;
   } dec_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value_main;
      logic [10:0] value_second;
      logic [6:0]  value_third;
      logic [7:0]  feature_flags;
      logic        digital_input;
   } record_type;

   localparam dec_state_type STATE_RESET = '{
      pos:         POS_W'(BLOCK_BYTES),
      header_good: 1'b1,
      recent:      24'h000000,
      chroma:      16'h0000,
      digital:     1'b0
   };

endpackage

FILE: design/edid_base_block_decoder.sv
// Decoder for the 128-byte base block of a display identification stream.
// The request channel carries one byte per transfer; req_block_start marks
// byte 0 and restarts the position count at any time. The response channel
// carries at most one decoded record per byte: the header check at byte 7,
// then, if the header was good, at most one record at the last byte of each field.
// Bytes that close no field, bytes of a block with a bad header and bytes
// past the end of the block give no response transfer.
// A record passes from the input register through the decode logic into the
// result register, which drives the response port; while the receiver stalls,
// a record can wait in the input register.
// Throughput is one byte per cycle, set by the single pass of decode logic
// between the two registers, while no record waits for the response register.
// After reset the block waits for a byte with req_block_start set; bytes
// before that are accepted and dropped. When the receiver stalls, the input
// register takes one more byte; a byte that would give a record waits there,
// and req_ready falls until the response register frees up. Bytes that give
// no record keep flowing during the stall.
module edid_base_block_decoder
   import edid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_record_kind,
   output logic [31:0] rsp_value_main,
   output logic [10:0] rsp_value_second,
   output logic [6:0]  rsp_value_third,
   output logic [7:0]  rsp_feature_flags,
   output logic        rsp_digital_input
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_start_ff;
   dec_state_type state_ff;
   dec_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   record_type    rsp_rec_ff;
   logic          dec_emit;
   record_type    dec_rec;
   logic          out_free;
   logic          s1_advance;
   logic          req_take;

   edid_field_decode u_decode (
      .data_byte   (s1_byte_ff),
      .block_start (s1_start_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .emit        (dec_emit),
      .rec         (dec_rec)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_advance   = s1_valid_ff && (!dec_emit || out_free);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign req_take     = req_valid && req_ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && dec_emit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_data_byte;
         s1_start_ff <= req_block_start;
      end
      if (s1_advance && dec_emit) begin
         rsp_rec_ff <= dec_rec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_record_kind   = rsp_rec_ff.kind;
   assign rsp_value_main    = rsp_rec_ff.value_main;
   assign rsp_value_second  = rsp_rec_ff.value_second;
   assign rsp_value_third   = rsp_rec_ff.value_third;
   assign rsp_feature_flags = rsp_rec_ff.feature_flags;
   assign rsp_digital_input = rsp_rec_ff.digital_input;

   a_ready_low_only_when_held : assert property (
      @(posedge clock) disable iff (reset) !req_ready |-> (s1_valid_ff && dec_emit)
   ) else $error("Input stalled without a pending record.");

   a_position_in_range : assert property (
      @(posedge clock) disable iff (reset) state_ff.pos <= POS_W'(BLOCK_BYTES)
   ) else $error("Byte position beyond the end of the block.");

   a_record_reaches_output : assert property (
      @(posedge clock) disable iff (reset) (s1_advance && dec_emit) |=> rsp_valid_ff
   ) else $error("Decoded record was lost.");

   a_stalled_record_kept : assert property (
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_rec_ff))
   ) else $error("Stalled record changed.");

   a_kind_known : assert property (
      @(posedge clock) disable iff (reset) rsp_valid_ff |-> (rsp_rec_ff.kind <= KIND_STANDARD)
   ) else $error("Record kind out of range.");

endmodule

FILE: design/edid_field_decode.sv
module edid_field_decode
   import edid_pkg::*;
(
   input  logic          [7:0] data_byte,
   input  logic                block_start,
   input  dec_state_type       state_cur,
   output dec_state_type       state_nxt,
   output logic                emit,
   output record_type          rec
);

   localparam logic [POS_W-1:0] POS_HDR_LAST   = POS_W'(7);
   localparam logic [POS_W-1:0] POS_BODY       = POS_W'(8);
   localparam logic [POS_W-1:0] POS_MAKER      = POS_W'(9);
   localparam logic [POS_W-1:0] POS_PRODUCT    = POS_W'(11);
   localparam logic [POS_W-1:0] POS_SERIAL     = POS_W'(15);
   localparam logic [POS_W-1:0] POS_DATE       = POS_W'(17);
   localparam logic [POS_W-1:0] POS_VERSION    = POS_W'(19);
   localparam logic [POS_W-1:0] POS_INPUT      = POS_W'(20);
   localparam logic [POS_W-1:0] POS_SIZE       = POS_W'(22);
   localparam logic [POS_W-1:0] POS_GAMMA      = POS_W'(23);
   localparam logic [POS_W-1:0] POS_FEATURES   = POS_W'(24);
   localparam logic [POS_W-1:0] POS_CHROMA_HI  = POS_W'(25);
   localparam logic [POS_W-1:0] POS_CHROMA_LO  = POS_W'(26);
   localparam logic [POS_W-1:0] POS_CHROMA_1ST = POS_W'(28);
   localparam logic [POS_W-1:0] POS_CHROMA_END = POS_W'(34);
   localparam logic [POS_W-1:0] POS_ESTAB      = POS_W'(36);
   localparam logic [POS_W-1:0] POS_RESERVED   = POS_W'(37);
   localparam logic [POS_W-1:0] POS_STD_1ST    = POS_W'(39);
   localparam logic [POS_W-1:0] POS_STD_END    = POS_W'(53);
   localparam logic [POS_W-1:0] POS_LIMIT      = POS_W'(BLOCK_BYTES);

   dec_state_type    st;
   logic [POS_W-1:0] p;
   logic [7:0]       p1;
   logic [7:0]       p2;
   logic [7:0]       p3;
   logic [15:0]      chroma_cur;
   logic [7:0]       want;
   logic [POS_W-1:0] chroma_off;
   logic [1:0]       colour;
   logic [7:0]       lo;
   logic [9:0]       chroma_x;
   logic [9:0]       chroma_y;
   logic [8:0]       q;
   logic [11:0]      q12;
   logic [11:0]      h_pixels;
   logic [19:0]      q_prod;
   logic [1:0]       aspect;
   logic [10:0]      v_pixels;
   logic [5:0]       feat;

   assign p          = block_start ? '0 : state_cur.pos;
   assign p1         = block_start ? 8'h00 : state_cur.recent[7:0];
   assign p2         = block_start ? 8'h00 : state_cur.recent[15:8];
   assign p3         = block_start ? 8'h00 : state_cur.recent[23:16];
   assign chroma_cur = block_start ? 16'h0000 : state_cur.chroma;

   // Standard timing: H = 8 * (b1 + 31); V follows from the aspect code.
   // For 5:4 the quotient 32q / 5 is formed as q * 3277 / 512, exact over the range.
   assign q        = {1'b0, p1} + 9'd31;
   assign q12      = {3'b000, q};
   assign h_pixels = {q, 3'b000};
   assign q_prod   = {11'd0, q} * 20'd3277;
   assign aspect   = data_byte[7:6];

   always_comb begin
      unique case (aspect)
         2'd0:    v_pixels = 11'((q12 << 2) + q12);
         2'd1:    v_pixels = 11'((q12 << 2) + (q12 << 1));
         2'd2:    v_pixels = q_prod[19:9];
         default: v_pixels = 11'(((q12 << 3) + q12) >> 1);
      endcase
   end

   assign chroma_off = p - POS_CHROMA_1ST;
   assign colour     = chroma_off[2:1];
   assign lo         = colour[1] ? chroma_cur[7:0] : chroma_cur[15:8];
   assign chroma_x   = {p1, (colour[0] ? lo[3:2] : lo[7:6])};
   assign chroma_y   = {data_byte, (colour[0] ? lo[1:0] : lo[5:4])};

   assign feat = {data_byte[0], data_byte[1], data_byte[2],
                  data_byte[5], data_byte[6], data_byte[7]};
   assign want = ((p == '0) || (p == POS_HDR_LAST)) ? 8'h00 : 8'hFF;

   always_comb begin
      st = state_cur;
      if (block_start) begin
         st.pos         = '0;
         st.header_good = 1'b1;
         st.recent      = '0;
         st.chroma      = '0;
         st.digital     = 1'b0;
      end
      emit = 1'b0;
      rec  = '0;

      if (p < POS_LIMIT) begin
         st.pos = p + POS_W'(1);
         if (p < POS_BODY) begin
            if (data_byte != want) begin
               st.header_good = 1'b0;
            end
            if (p == POS_HDR_LAST) begin
               emit           = 1'b1;
               rec.kind       = KIND_HEADER;
               rec.value_main = {31'd0, st.header_good};
            end
         end else if (st.header_good) begin
            if (p == POS_MAKER) begin
               emit           = 1'b1;
               rec.kind       = KIND_MAKER;
               rec.value_main = {17'd0, p1[6:0], data_byte};
            end else if (p == POS_PRODUCT) begin
               emit           = 1'b1;
               rec.kind       = KIND_PRODUCT;
               rec.value_main = {16'd0, data_byte, p1};
            end else if (p == POS_SERIAL) begin
               emit           = 1'b1;
               rec.kind       = KIND_SERIAL;
               rec.value_main = {data_byte, p1, p2, p3};
            end else if (p == POS_DATE) begin
               emit             = 1'b1;
               rec.kind         = KIND_DATE;
               rec.value_main   = 32'd1990 + {24'd0, data_byte};
               rec.value_second = {3'd0, p1};
            end else if (p == POS_VERSION) begin
               emit             = 1'b1;
               rec.kind         = KIND_VERSION;
               rec.value_main   = {24'd0, p1};
               rec.value_second = {3'd0, data_byte};
            end else if (p == POS_INPUT) begin
               st.digital      = data_byte[7];
               emit            = 1'b1;
               rec.kind        = KIND_INPUT;
               rec.value_third = {3'd0, data_byte[3:0]};
               if (data_byte[7]) begin
                  rec.value_second  = {8'd0, data_byte[6:4]};
                  rec.feature_flags = {(data_byte[3:0] >= 4'd6), 7'd0};
               end else begin
                  rec.value_second  = {9'd0, data_byte[6:5]};
                  rec.feature_flags = {1'b0, data_byte[4], 6'd0};
               end
            end else if (p == POS_SIZE) begin
               emit             = 1'b1;
               rec.kind         = KIND_SIZE;
               rec.value_main   = {24'd0, p1};
               rec.value_second = {3'd0, data_byte};
            end else if (p == POS_GAMMA) begin
               emit           = 1'b1;
               rec.kind       = KIND_GAMMA;
               rec.value_main = {24'd0, data_byte} + 32'd100;
            end else if (p == POS_FEATURES) begin
               emit              = 1'b1;
               rec.kind          = KIND_FEATURES;
               rec.value_third   = {5'd0, data_byte[4:3]};
               rec.feature_flags = {2'd0, feat};
            end else if (p == POS_CHROMA_HI) begin
               st.chroma = {data_byte, 8'h00};
            end else if (p == POS_CHROMA_LO) begin
               st.chroma[7:0] = data_byte;
            end else if (p >= POS_CHROMA_1ST && p <= POS_CHROMA_END && !p[0]) begin
               emit             = 1'b1;
               rec.kind         = KIND_CHROMA;
               rec.value_main   = {22'd0, chroma_x};
               rec.value_second = {1'b0, chroma_y};
               rec.value_third  = {5'd0, colour};
            end else if (p == POS_ESTAB) begin
               emit           = 1'b1;
               rec.kind       = KIND_ESTABLISHED;
               rec.value_main = {16'd0, p1, data_byte};
            end else if (p == POS_RESERVED) begin
               if (data_byte != 8'h00) begin
                  emit           = 1'b1;
                  rec.kind       = KIND_RESERVED;
                  rec.value_main = {24'd0, data_byte};
               end
            end else if (p >= POS_STD_1ST && p <= POS_STD_END && p[0]) begin
               if (!(p1 == 8'h01 && data_byte == 8'h01)) begin
                  emit              = 1'b1;
                  rec.kind          = KIND_STANDARD;
                  rec.value_main    = {20'd0, h_pixels};
                  rec.value_second  = v_pixels;
                  rec.value_third   = 7'(data_byte[5:0]) + 7'd60;
                  rec.feature_flags = {6'd0, aspect};
               end
            end
         end
         st.recent = {st.recent[15:0], data_byte};
      end

      rec.digital_input = st.digital;
      state_nxt         = st;
   end

endmodule
